[src/slr_pkg.sv]
package slr_pkg;

   localparam int TimeWidth  = 32;
   localparam int LimitWidth = 25;
   localparam int StateWidth = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [LimitWidth-1:0] DownWaitReset   = 25'd30000000;
   localparam logic [LimitWidth-1:0] ResetHoldReset  = 25'd100000;
   localparam logic [LimitWidth-1:0] SettleWaitReset = 25'd1000000;

   // register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CsrDownWait   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrResetHold  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrSettleWait = 2'd2;

   // bit positions in the reset drive word
   localparam int DrvProto = 0;
   localparam int DrvGt    = 1;

   typedef struct packed {
      logic [TimeWidth-1:0] now_us;
      logic                 channel_up;
   } slr_item_type;

   typedef struct packed {
      logic                  gt_reset;
      logic                  proto_reset;
      logic [StateWidth-1:0] link_state;
      logic                  state_changed;
   } slr_result_type;

   typedef struct packed {
      logic [LimitWidth-1:0] down_wait_us;
      logic [LimitWidth-1:0] reset_hold_us;
      logic [LimitWidth-1:0] settle_wait_us;
   } slr_cfg_type;

endpackage

[src/slr_if.sv]
interface slr_req_if;
   import slr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TimeWidth-1:0] now_us;
   logic                 channel_up;

   modport source (output valid, output now_us, output channel_up, input ready);
   modport sink (input valid, input now_us, input channel_up, output ready);
endinterface

interface slr_rsp_if;
   import slr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  gt_reset;
   logic                  proto_reset;
   logic [StateWidth-1:0] link_state;
   logic                  state_changed;

   modport source (output valid, output gt_reset, output proto_reset,
                   output link_state, output state_changed, input ready);
   modport sink (input valid, input gt_reset, input proto_reset,
                 input link_state, input state_changed, output ready);
endinterface

[src/slr_cfg.sv]
module slr_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [slr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [slr_pkg::LimitWidth-1:0]   csr_data,
   output slr_pkg::slr_cfg_type             cfg
);
   import slr_pkg::*;

   slr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CsrDownWait:   cfg_in.down_wait_us   = csr_data;
            CsrResetHold:  cfg_in.reset_hold_us  = csr_data;
            CsrSettleWait: cfg_in.settle_wait_us = csr_data;
            default:       cfg_in = cfg_ff;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_wait_us   <= DownWaitReset;
         cfg_ff.reset_hold_us  <= ResetHoldReset;
         cfg_ff.settle_wait_us <= SettleWaitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/slr_core.sv]
module slr_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  slr_pkg::slr_item_type   item,
   input  slr_pkg::slr_cfg_type    cfg,
   output slr_pkg::slr_result_type result
);
   import slr_pkg::*;

   typedef enum logic [StateWidth-1:0] {
      ST_UP    = 3'd0,
      ST_DOWN1 = 3'd1,
      ST_PRST1 = 3'd2,
      ST_DOWN2 = 3'd3,
      ST_BOTH  = 3'd4,
      ST_PRST2 = 3'd5
   } state_type;

   state_type             state_ff, state_in;
   logic [TimeWidth-1:0]  start_ff, start_in;
   logic [LimitWidth-1:0] limit_ff, limit_in;
   logic [1:0]            drive_ff, drive_in;
   logic [TimeWidth-1:0]  elapsed;
   logic                  timeout;

   assign elapsed = item.now_us - start_ff;
   assign timeout = elapsed > {{(TimeWidth-LimitWidth){1'b0}}, limit_ff};

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      limit_in = limit_ff;
      drive_in = drive_ff;
      case (state_ff)
         ST_DOWN1: begin
            if (item.channel_up) begin
               state_in = ST_UP;
            end else if (timeout) begin
               drive_in[DrvProto] = 1'b1;
               start_in = item.now_us;
               limit_in = cfg.reset_hold_us;
               state_in = ST_PRST1;
            end
         end
         ST_PRST1: begin
            if (timeout) begin
               drive_in[DrvProto] = 1'b0;
               start_in = item.now_us;
               limit_in = cfg.settle_wait_us;
               state_in = ST_DOWN2;
            end
         end
         ST_DOWN2: begin
            if (item.channel_up) begin
               state_in = ST_UP;
            end else if (timeout) begin
               drive_in = 2'b11;
               start_in = item.now_us;
               limit_in = cfg.reset_hold_us;
               state_in = ST_BOTH;
            end
         end
         ST_BOTH: begin
            if (timeout) begin
               drive_in[DrvGt] = 1'b0;
               start_in = item.now_us;
               limit_in = cfg.settle_wait_us;
               state_in = ST_PRST2;
            end
         end
         ST_PRST2: begin
            if (timeout) begin
               drive_in[DrvProto] = 1'b0;
               start_in = item.now_us;
               limit_in = cfg.down_wait_us;
               state_in = ST_DOWN1;
            end
         end
         default: begin
            // up, and the unreachable codes behave the same way
            if (!item.channel_up) begin
               drive_in = 2'b00;
               start_in = item.now_us;
               limit_in = cfg.down_wait_us;
               state_in = ST_DOWN1;
            end
         end
      endcase
   end

   assign result.gt_reset      = drive_in[DrvGt];
   assign result.proto_reset   = drive_in[DrvProto];
   assign result.link_state    = state_in;
   assign result.state_changed = (state_in != state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_UP;
         start_ff <= '0;
         limit_ff <= '0;
         drive_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         start_ff <= start_in;
         limit_ff <= limit_in;
         drive_ff <= drive_in;
      end
   end

endmodule

[src/serial_link_recovery_fsm.sv]
// Link watchdog and recovery sequencer for one serial link. Each req transfer is one
// tick (microsecond time plus channel-up status) and yields exactly one rsp transfer
// with the reset drives, the link state and a state-changed flag, all as they stand
// after that tick. Throughput is one transfer per clock while rsp is ready; a tick
// passes through the input register and the result register, with the subtract,
// compare and state update in between. The three timing registers are written
// through the csr_ port; a new value takes effect at the next interval start, so
// write them only while no tick is in flight.
module serial_link_recovery_fsm (
   input  logic                            clock,
   input  logic                            reset,
   slr_req_if.sink                         req,
   slr_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [slr_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [slr_pkg::LimitWidth-1:0]  csr_data
);
   import slr_pkg::*;

   logic           in_valid_ff;
   slr_item_type   in_item_ff;
   logic           out_valid_ff;
   slr_result_type out_result_ff;
   slr_result_type step_result;
   slr_cfg_type    cfg;
   logic           advance;

   // advance the held tick when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   slr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // state commits only when the tick moves into the result register
   slr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // payload: capture on an accepted transfer, otherwise hold
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff.now_us     <= req.now_us;
         in_item_ff.channel_up <= req.channel_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.gt_reset      = out_result_ff.gt_reset;
   assign rsp.proto_reset   = out_result_ff.proto_reset;
   assign rsp.link_state    = out_result_ff.link_state;
   assign rsp.state_changed = out_result_ff.state_changed;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

typedef enum logic [slr_pkg::StateWidth-1:0] {
   LinkUp     = 3'd0,
   LinkDown1  = 3'd1,
   LinkProto1 = 3'd2,
   LinkDown2  = 3'd3,
   LinkBoth   = 3'd4,
   LinkProto2 = 3'd5
} link_phase_type;

class link_scoreboard;
   logic [slr_pkg::LimitWidth-1:0] down_wait_us;
   logic [slr_pkg::LimitWidth-1:0] reset_hold_us;
   logic [slr_pkg::LimitWidth-1:0] settle_wait_us;
   link_phase_type                 link_phase;
   logic [slr_pkg::TimeWidth-1:0]  interval_start;
   logic [slr_pkg::LimitWidth-1:0] interval_limit;
   logic [1:0]                     drive;
   slr_pkg::slr_result_type        due[$];
   int                             errors;
   int                             ticks;
   int                             results;
   bit [7:0]                       reached;

   function new();
      down_wait_us   = slr_pkg::DownWaitReset;
      reset_hold_us  = slr_pkg::ResetHoldReset;
      settle_wait_us = slr_pkg::SettleWaitReset;
      link_phase     = LinkUp;
      interval_start = '0;
      interval_limit = '0;
      drive          = '0;
      errors         = 0;
      ticks          = 0;
      results        = 0;
      reached        = 8'b1;
   endfunction

   function void write_timing(logic [slr_pkg::CsrIdxWidth-1:0] index,
                              logic [slr_pkg::LimitWidth-1:0] value);
      case (index)
         slr_pkg::CsrDownWait:   down_wait_us   = value;
         slr_pkg::CsrResetHold:  reset_hold_us  = value;
         slr_pkg::CsrSettleWait: settle_wait_us = value;
         default: ;
      endcase
   endfunction

   function void open_interval(logic [slr_pkg::TimeWidth-1:0] now_us,
                               logic [slr_pkg::LimitWidth-1:0] span, link_phase_type next);
      interval_start = now_us;
      interval_limit = span;
      link_phase     = next;
   endfunction

   // advance the sequencer by one accepted tick and queue what it must report
   function void note_tick(logic [slr_pkg::TimeWidth-1:0] now_us, logic channel_up);
      link_phase_type                prior;
      logic [slr_pkg::TimeWidth-1:0] elapsed;
      logic                          expired;
      prior   = link_phase;
      elapsed = now_us - interval_start;
      expired = elapsed > 32'(interval_limit);
      case (prior)
         LinkDown1: begin
            if (channel_up) begin
               link_phase = LinkUp;
            end else if (expired) begin
               drive[slr_pkg::DrvProto] = 1'b1;
               open_interval(now_us, reset_hold_us, LinkProto1);
            end
         end
         LinkProto1: begin
            if (expired) begin
               drive[slr_pkg::DrvProto] = 1'b0;
               open_interval(now_us, settle_wait_us, LinkDown2);
            end
         end
         LinkDown2: begin
            if (channel_up) begin
               link_phase = LinkUp;
            end else if (expired) begin
               drive[slr_pkg::DrvProto] = 1'b1;
               drive[slr_pkg::DrvGt]    = 1'b1;
               open_interval(now_us, reset_hold_us, LinkBoth);
            end
         end
         LinkBoth: begin
            if (expired) begin
               drive[slr_pkg::DrvGt] = 1'b0;
               open_interval(now_us, settle_wait_us, LinkProto2);
            end
         end
         LinkProto2: begin
            if (expired) begin
               drive[slr_pkg::DrvProto] = 1'b0;
               open_interval(now_us, down_wait_us, LinkDown1);
            end
         end
         default: begin
            if (!channel_up) begin
               drive = '0;
               open_interval(now_us, down_wait_us, LinkDown1);
            end
         end
      endcase
      ticks++;
      reached[link_phase] = 1'b1;
      due.push_back('{gt_reset:      drive[slr_pkg::DrvGt],
                      proto_reset:   drive[slr_pkg::DrvProto],
                      link_state:    link_phase,
                      state_changed: link_phase != prior});
   endfunction

   function void flag(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   function void check_result(slr_pkg::slr_result_type got);
      slr_pkg::slr_result_type want;
      results++;
      if (due.size() == 0) begin
         errors++;
         $display("%0t: result with none expected, actual %h", $time, got);
         return;
      end
      want = due.pop_front();
      if (got.gt_reset !== want.gt_reset)
         flag("gt_reset", 8'(want.gt_reset), 8'(got.gt_reset));
      if (got.proto_reset !== want.proto_reset)
         flag("proto_reset", 8'(want.proto_reset), 8'(got.proto_reset));
      if (got.link_state !== want.link_state)
         flag("link_state", 8'(want.link_state), 8'(got.link_state));
      if (got.state_changed !== want.state_changed)
         flag("state_changed", 8'(want.state_changed), 8'(got.state_changed));
   endfunction
endclass

module tb;
   import slr_pkg::*;

   // index 3 maps to no register; writes to it must leave the timing alone
   localparam logic [CsrIdxWidth-1:0] CsrSpare = 2'd3;
   localparam logic [LimitWidth-1:0]  LimitMax = '1;
   localparam int Latency     = 2;
   localparam int PhaseItems  = 285;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [LimitWidth-1:0]   csr_data;
   bit                      steady;
   logic [TimeWidth-1:0]    wall_us;
   int                      settings;
   link_scoreboard          board;

   slr_req_if req ();
   slr_rsp_if rsp ();

   serial_link_recovery_fsm uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Stall the result side at random with probability 0.31, except while the run is steady.
   always @(posedge clock) begin
      rsp.ready <= steady || ($urandom_range(0, 99) >= 31);
   end

   // Every result transfer is checked against the oldest queued prediction.
   // Values read here are the ones present at the edge, since all drives are
   // nonblocking.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(slr_result_type'({rsp.gt_reset, rsp.proto_reset,
                                              rsp.link_state, rsp.state_changed}));
   end

   // Offer one tick, idling the request side at random first; hold valid high
   // across back-to-back transfers so it is never dropped and raised in one step.
   task automatic send_tick(logic [TimeWidth-1:0] now_us, logic channel_up);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.now_us     <= now_us;
      req.channel_up <= channel_up;
      do @(posedge clock); while (!req.ready);
      board.note_tick(now_us, channel_up);
   endtask

   // Drop valid and hold off until every predicted result has been seen.
   task automatic wait_for_results();
      req.valid <= 1'b0;
      do @(posedge clock); while (board.due.size() != 0);
   endtask

   // Load all three timing registers plus the unmapped index, with the block idle.
   task automatic load_timing(logic [LimitWidth-1:0] down_wait,
                              logic [LimitWidth-1:0] hold,
                              logic [LimitWidth-1:0] settle);
      logic [CsrIdxWidth-1:0] index_list[4];
      logic [LimitWidth-1:0]  value_list[4];
      index_list = '{CsrDownWait, CsrResetHold, CsrSettleWait, CsrSpare};
      value_list = '{down_wait, hold, settle, LimitWidth'($urandom())};
      wait_for_results();
      repeat (Latency + 2) @(posedge clock);
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= index_list[k];
         csr_data  <= value_list[k];
         @(posedge clock);
         board.write_timing(index_list[k], value_list[k]);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   // Random ticks. Most advance time a little or land right on the interval
   // boundary so the sequence walks through every recovery step; the rest jump
   // anywhere, including just short of the wrap.
   task automatic run_phase(int count, int up_pct);
      int                   pause_at;
      int                   roll;
      logic [TimeWidth-1:0] span;
      pause_at = $urandom_range(count / 4, 3 * count / 4);
      span     = 32'(board.down_wait_us);
      if (32'(board.reset_hold_us) > span) span = 32'(board.reset_hold_us);
      if (32'(board.settle_wait_us) > span) span = 32'(board.settle_wait_us);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_for_results();
         roll = $urandom_range(0, 99);
         if (roll < 50)
            wall_us += $urandom_range(0, 3);
         else if (roll < 70)
            wall_us += $urandom_range(0, 2 * span + 2);
         else if (roll < 85)
            wall_us = board.interval_start + 32'(board.interval_limit) + $urandom_range(0, 1);
         else if (roll < 92)
            wall_us = $urandom();
         else if (roll < 95)
            wall_us = 32'hFFFF_FFFF - $urandom_range(0, 3);
         // otherwise repeat the same time stamp
         send_tick(wall_us, $urandom_range(0, 99) < up_pct);
      end
   endtask

   initial begin
      slr_item_type opening[22];
      // Walk the full recovery loop with the reset timing: leave up across the
      // wrap, sit exactly on each boundary, see channel up ignored while a
      // reset is driven and honored in both down waits.
      opening = '{
         {32'h0000_0000, 1'b1}, {32'hFFFF_FFF0, 1'b0}, {32'hFFFF_FFFF, 1'b0},
         {32'h0100_0000, 1'b0}, {32'h01C9_C370, 1'b0}, {32'h01C9_C371, 1'b0},
         {32'h01CB_4A11, 1'b1}, {32'h01CB_4A12, 1'b1}, {32'h01CB_4A13, 1'b1},
         {32'h01CB_4A14, 1'b0}, {32'h01CB_4A15, 1'b1}, {32'h01CB_4A16, 1'b0},
         {32'h8000_0000, 1'b0}, {32'h8002_0000, 1'b0}, {32'h9000_0000, 1'b0},
         {32'hA000_0000, 1'b1}, {32'hB000_0000, 1'b1}, {32'hB000_0001, 1'b1},
         {32'hFFFF_FFFF, 1'b0}, {32'h0000_0000, 1'b0}, {32'h5555_5555, 1'b0},
         {32'hAAAA_AAAA, 1'b1}
      };
      board          = new();
      req.valid      = 1'b0;
      req.now_us     = '0;
      req.channel_up = 1'b1;
      rsp.ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CsrDownWait;
      csr_data       = '0;
      steady         = 1'b0;
      settings       = 1;
      wall_us        = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[k]) send_tick(opening[k].now_us, opening[k].channel_up);
      wall_us = opening[21].now_us;

      // zero limits: any advance of time is a timeout
      load_timing('0, '0, '0);
      run_phase(PhaseItems, 15);
      // widest limits: only large jumps or boundary hits move on
      load_timing(LimitMax, LimitMax, LimitMax);
      run_phase(PhaseItems, 15);
      // short limits, both sides streaming with no idle cycles
      steady = 1'b1;
      load_timing(LimitWidth'($urandom_range(1, 8)), LimitWidth'($urandom_range(1, 8)),
                  LimitWidth'($urandom_range(1, 8)));
      run_phase(PhaseItems, 15);
      steady = 1'b0;
      // small limits with a flapping channel
      load_timing(LimitWidth'($urandom_range(0, 20)), LimitWidth'($urandom_range(0, 20)),
                  LimitWidth'($urandom_range(0, 20)));
      run_phase(PhaseItems, 50);
      load_timing('0, LimitMax, LimitWidth'($urandom_range(1, 6)));
      run_phase(PhaseItems, 15);
      load_timing(LimitWidth'($urandom()), LimitWidth'($urandom()), LimitWidth'($urandom()));
      run_phase(PhaseItems, 15);
      // mostly up: the down waits are cut short
      load_timing(LimitWidth'($urandom_range(0, 4)), LimitWidth'($urandom_range(0, 4)),
                  LimitWidth'($urandom_range(0, 4)));
      run_phase(PhaseItems, 85);

      wait_for_results();
      repeat (Latency + 4) @(posedge clock);

      $display("run: %0d ticks sent, %0d results checked, %0d timing settings loaded",
               board.ticks, board.results, settings);
      $display("run: link states reached %b (bit n = state n), %0d field errors",
               board.reached, board.errors);
      if (board.errors == 0 && board.due.size() == 0) begin
         $display("serial_link_recovery_fsm: match");
      end else begin
         $display("serial_link_recovery_fsm: mismatch");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("serial_link_recovery_fsm: mismatch");
      $finish;
   end

endmodule
